// ----- src/damped_particle_integrator_core_macros.svh -----
// Assertion helpers, sampled on clk and disabled while rst is high.
`ifndef DAMPED_PARTICLE_INTEGRATOR_CORE_MACROS_SVH
`define DAMPED_PARTICLE_INTEGRATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define DPINT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPINT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dpint_pkg.sv -----
`default_nettype none
package dpint_pkg;

  localparam int AxisCount = 3;
  localparam int AxisW     = 2;
  localparam logic [AxisW-1:0] AxisLast = 2'd2;

  localparam int MassW    = 31;
  localparam int DampW    = 17;
  localparam int DtW      = 31;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_MASS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DAMP   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DT     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STATIC = 2'd3;

  localparam logic [MassW-1:0] MassReset = 31'd327680;
  localparam logic [DampW-1:0] DampReset = 17'd64881;
  localparam logic [DtW-1:0]   DtReset   = 31'd1092;

  localparam int ActW = 3;
  localparam logic [ActW-1:0] ACT_FORCE = 3'd0;
  localparam logic [ActW-1:0] ACT_STEP  = 3'd1;
  localparam logic [ActW-1:0] ACT_POS   = 3'd2;
  localparam logic [ActW-1:0] ACT_VEL   = 3'd3;
  localparam logic [ActW-1:0] ACT_ACC   = 3'd4;
  localparam logic [ActW-1:0] ACT_CLEAR = 3'd5;

  // Divider: (|F| << 16) / mass, one quotient bit per cycle
  localparam int DivNumW  = 48;
  localparam int DivSteps = DivNumW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [MassW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > QMax) begin
      r = 32'sh7fffffff;
    end else if (x < QMin) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sext64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Divide by 2^sh, rounding halves away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                     input int unsigned sh);
    logic        neg;
    logic [63:0] mag;
    neg = p[63];
    mag = neg ? 64'(-p) : 64'(p);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

endpackage
`default_nettype wire

// ----- src/dpint_if.sv -----
`default_nettype none
interface dpint_req_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic signed [31:0]      vec_x;
  logic signed [31:0]      vec_y;
  logic signed [31:0]      vec_z;

  modport source (output valid, action, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, action, vec_x, vec_y, vec_z, output ready);
endinterface

interface dpint_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface
`default_nettype wire

// ----- src/damped_particle_integrator_core.sv -----
// Load, clear, add-force, static-step and unused-code items go from acceptance straight
// to the output register; an integrate step first runs, per axis, a radix-2 division by
// mass and then its shared-multiplier work, three axes in turn.
// Throughput: one item in work at a time; the next is accepted once the result is queued
// in the output register, which waits while an earlier result has not been taken.
// Reset (rst, synchronous): state vectors zero, registers at defaults, no result pending.
`default_nettype none
`include "damped_particle_integrator_core_macros.svh"
module damped_particle_integrator_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  dpint_req_if.sink                               req,
  dpint_rsp_if.source                             rsp,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dpint_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [dpint_pkg::CfgDataW-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_GO   = 4'd1;
  localparam logic [3:0] S_DIV_WAIT = 4'd2;
  localparam logic [3:0] S_ACC      = 4'd3;
  localparam logic [3:0] S_MUL_DTA  = 4'd4;
  localparam logic [3:0] S_VEL1     = 4'd5;
  localparam logic [3:0] S_MUL_DAMP = 4'd6;
  localparam logic [3:0] S_VEL2     = 4'd7;
  localparam logic [3:0] S_MUL_POS  = 4'd8;
  localparam logic [3:0] S_POS      = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state;

  logic [dpint_pkg::MassW-1:0] particle_mass;
  logic [dpint_pkg::DampW-1:0] damping_factor;
  logic [dpint_pkg::DtW-1:0]   time_step;
  logic                        is_static;

  logic signed [31:0] pos   [dpint_pkg::AxisCount];
  logic signed [31:0] vel   [dpint_pkg::AxisCount];
  logic signed [31:0] acc   [dpint_pkg::AxisCount];
  logic signed [31:0] force_sum [dpint_pkg::AxisCount];
  logic signed [31:0] vec   [dpint_pkg::AxisCount];

  logic [dpint_pkg::AxisW-1:0] axis;
  logic signed [48:0]          quo_s;
  logic signed [31:0]          accel;
  logic signed [31:0]          tmp;
  logic signed [63:0]          dta;
  logic signed [63:0]          prod;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic signed [31:0] out_pos [dpint_pkg::AxisCount];
  logic signed [31:0] out_vel [dpint_pkg::AxisCount];
  logic               out_valid;
  logic               accept;
  logic               out_load;
  logic               step_go;
  logic               step_last;
  logic               force_zero;

  logic [31:0]         f_mag;
  logic signed [31:0]  v2;
  dpint_pkg::div_req_t div_req;
  dpint_pkg::div_rsp_t div_rsp;

  assign vec[0] = req.vec_x;
  assign vec[1] = req.vec_y;
  assign vec[2] = req.vec_z;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_OUT) && (!out_valid || rsp.ready);
  assign step_go   = (req.action == dpint_pkg::ACT_STEP) && !is_static;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_mass  <= dpint_pkg::MassReset;
      damping_factor <= dpint_pkg::DampReset;
      time_step      <= dpint_pkg::DtReset;
      is_static      <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dpint_pkg::CFG_MASS:   particle_mass  <= cfg_data[dpint_pkg::MassW-1:0];
        dpint_pkg::CFG_DAMP:   damping_factor <= cfg_data[dpint_pkg::DampW-1:0];
        dpint_pkg::CFG_DT:     time_step      <= cfg_data[dpint_pkg::DtW-1:0];
        dpint_pkg::CFG_STATIC: is_static      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divider request for the current axis; a zero mass acts as one LSB
  assign f_mag = force_sum[axis][31] ? 32'(-force_sum[axis]) : 32'(force_sum[axis]);
  assign div_req.start = (state == S_DIV_GO);
  assign div_req.num   = {f_mag, 16'h0000};
  assign div_req.den   = (particle_mass == '0) ? dpint_pkg::MassW'(1) : particle_mass;

  dpint_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL_DAMP: begin
        mul_a = {tmp[31], tmp};
        mul_b = signed'({16'h0000, damping_factor});
      end
      S_MUL_POS: begin
        mul_a = signed'({2'b00, time_step});
        mul_b = {tmp[31], tmp};
      end
      default: begin
        mul_a = signed'({2'b00, time_step});
        mul_b = {accel[31], accel};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign v2 = dpint_pkg::sat32(dpint_pkg::round_shift(prod, 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      for (int k = 0; k < dpint_pkg::AxisCount; k++) begin
        pos[k]       <= '0;
        vel[k]       <= '0;
        acc[k]       <= '0;
        force_sum[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= step_go ? S_DIV_GO : S_OUT;
            unique case (req.action)
              dpint_pkg::ACT_FORCE: begin
                for (int k = 0; k < dpint_pkg::AxisCount; k++) begin
                  force_sum[k] <= dpint_pkg::sat32(dpint_pkg::sext64(force_sum[k]) +
                                                   dpint_pkg::sext64(vec[k]));
                end
              end
              dpint_pkg::ACT_STEP: begin
                if (!is_static) axis <= '0;
              end
              dpint_pkg::ACT_POS: begin
                for (int k = 0; k < dpint_pkg::AxisCount; k++) pos[k] <= vec[k];
              end
              dpint_pkg::ACT_VEL: begin
                for (int k = 0; k < dpint_pkg::AxisCount; k++) vel[k] <= vec[k];
              end
              dpint_pkg::ACT_ACC: begin
                for (int k = 0; k < dpint_pkg::AxisCount; k++) acc[k] <= vec[k];
              end
              dpint_pkg::ACT_CLEAR: begin
                for (int k = 0; k < dpint_pkg::AxisCount; k++) begin
                  acc[k]       <= '0;
                  force_sum[k] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            quo_s <= force_sum[axis][31] ? -signed'({1'b0, div_rsp.quo})
                                         : signed'({1'b0, div_rsp.quo});
            state <= S_ACC;
          end
        end
        S_ACC: begin
          accel <= dpint_pkg::sat32(dpint_pkg::sext64(acc[axis]) +
                                    {{15{quo_s[48]}}, quo_s});
          state <= S_MUL_DTA;
        end
        S_MUL_DTA: begin
          dta   <= mul_p[63:0];
          state <= S_VEL1;
        end
        S_VEL1: begin
          tmp   <= dpint_pkg::sat32(dpint_pkg::sext64(vel[axis]) +
                                    dpint_pkg::round_shift(dta, 16));
          state <= S_MUL_DAMP;
        end
        S_MUL_DAMP: begin
          prod  <= mul_p[63:0];
          state <= S_VEL2;
        end
        S_VEL2: begin
          vel[axis] <= v2;
          tmp       <= dpint_pkg::sat32(dpint_pkg::sext64(v2) +
                                        dpint_pkg::round_shift(dta, 17));
          state     <= S_MUL_POS;
        end
        S_MUL_POS: begin
          prod  <= mul_p[63:0];
          state <= S_POS;
        end
        S_POS: begin
          pos[axis]       <= dpint_pkg::sat32(dpint_pkg::sext64(pos[axis]) +
                                              dpint_pkg::round_shift(prod, 16));
          force_sum[axis] <= '0;
          if (axis == dpint_pkg::AxisLast) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIV_GO;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int k = 0; k < dpint_pkg::AxisCount; k++) begin
        out_pos[k] <= pos[k];
        out_vel[k] <= vel[k];
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.pos_x = out_pos[0];
  assign rsp.pos_y = out_pos[1];
  assign rsp.pos_z = out_pos[2];
  assign rsp.vel_x = out_vel[0];
  assign rsp.vel_y = out_vel[1];
  assign rsp.vel_z = out_vel[2];

  assign step_last  = (state == S_POS) && (axis == dpint_pkg::AxisLast);
  assign force_zero = (force_sum[0] == '0) && (force_sum[1] == '0) && (force_sum[2] == '0);

  `DPINT_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted")
  `DPINT_ASSERT_NXT(a_force_cleared, step_last, force_zero, "force sum not cleared")
  `DPINT_ASSERT_IMP(a_result_from_out, $rose(out_valid), $past(state) == S_OUT, "stray result")

endmodule
`default_nettype wire

// ----- src/dpint_div.sv -----
`default_nettype none
module dpint_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dpint_pkg::div_req_t req,
  output dpint_pkg::div_rsp_t      rsp
);

  logic                              busy;
  logic                              done;
  logic [dpint_pkg::DivCntW-1:0]     cnt;
  logic [dpint_pkg::DivNumW-1:0]     work;
  logic [dpint_pkg::MassW-1:0]       rem;
  logic [dpint_pkg::MassW-1:0]       den;
  logic [dpint_pkg::MassW:0]         rem_sh;
  logic [dpint_pkg::MassW+1:0]       diff;

  assign rem_sh = {rem, work[dpint_pkg::DivNumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= dpint_pkg::DivCntW'(dpint_pkg::DivSteps);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == dpint_pkg::DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring step: quotient bits shift in behind the numerator
  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      den  <= req.den;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[dpint_pkg::DivNumW-2:0], ~diff[dpint_pkg::MassW+1]};
      rem  <= diff[dpint_pkg::MassW+1] ? rem_sh[dpint_pkg::MassW-1:0]
                                       : diff[dpint_pkg::MassW-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = work;

endmodule
`default_nettype wire
